// ----- design/nps_pkg.sv -----
// Package for the next prime search block: widths, search constants and state codes.
// Used by the channel interfaces, the shared divider and the top level.
package nps_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int START_W         = 32;
  localparam int PRIME_W         = 32;

  localparam int SMALL_PRIME   = 2;
  localparam int LAST_TRIVIAL  = 3;
  localparam int DIV_THREE     = 3;
  localparam int FIRST_DIVISOR = 5;
  localparam int PAIR_GAP      = 2;
  localparam int DIVISOR_STEP  = 6;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CAND = 6'b000010,
    S_DIV3 = 6'b000100,
    S_DIVA = 6'b001000,
    S_DIVB = 6'b010000,
    S_OUT  = 6'b100000
  } nps_state_t;

endpackage

// ----- design/nps_if.sv -----
// Valid/ready channel interfaces for the next prime search block.
// Depends on nps_pkg for the payload widths.
interface nps_in_if;
  import nps_pkg::*;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_value;
  modport source(output valid, output start_value, input ready);
  modport sink(input valid, input start_value, output ready);
endinterface

interface nps_out_if;
  import nps_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRIME_W-1:0] prime_found;
  logic               overflow;
  modport source(output valid, output prime_found, output overflow, input ready);
  modport sink(input valid, input prime_found, input overflow, output ready);
endinterface

// ----- design/nps_div.sv -----
// Shared restoring divider: one quotient bit per cycle, quotient and remainder held after done.
// Sized by the VALUE_WIDTH parameter handed down from the top level; its default comes from nps_pkg.
module nps_div #(
  parameter int VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);
  localparam int CW = $clog2(VALUE_WIDTH);

  logic                   busy_r;
  logic                   done_r;
  logic [CW-1:0]          cnt_r;
  logic [VALUE_WIDTH-1:0] dvd_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] dsr_r;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  assign trial = {rem_r, dvd_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= CW'(VALUE_WIDTH - 1);
    end else if (busy_r) begin
      rem_r <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      dvd_r <= {dvd_r[VALUE_WIDTH-2:0], fits};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// ----- design/next_prime_search.sv -----
// Next prime search: smallest prime above start_value by 6k+-1 trial division, else overflow.
// Each division runs on the shared divider; a candidate costs up to
// about 2 + sqrt(c) / 3 divisions.
// One item at a time: a new beat is taken only after the result beat has been taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops any search.
// Depends on nps_pkg, nps_if and nps_div.
module next_prime_search #(
  parameter int VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nps_in_if.sink     in_chan,
  nps_out_if.source  out_chan
);
  import nps_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] MASK = {W{1'b1}};

  nps_state_t         state_r, state_nxt;
  logic [W-1:0]       c_r, c_nxt;
  logic [W-1:0]       d_r, d_nxt;
  logic [W-1:0]       dsr_r, dsr_nxt;
  logic               div_start_r, div_start_nxt;
  logic [PRIME_W-1:0] prime_r, prime_nxt;
  logic               ovf_r, ovf_nxt;
  logic [W-1:0]       in_val;
  logic               reject;
  logic               found;
  logic               div_done;
  logic [W-1:0]       div_quo;
  logic [W-1:0]       div_rem;

  assign in_val = W'(in_chan.start_value);

  nps_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (c_r),
    .divisor   (dsr_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    dsr_nxt       = dsr_r;
    div_start_nxt = 1'b0;
    prime_nxt     = prime_r;
    ovf_nxt       = ovf_r;
    reject        = 1'b0;
    found         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_val <= W'(1)) begin
            prime_nxt = PRIME_W'(SMALL_PRIME);
            ovf_nxt   = 1'b0;
            state_nxt = S_OUT;
          end else if (in_val == MASK) begin
            prime_nxt = '0;
            ovf_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            c_nxt     = in_val + W'(1);
            state_nxt = S_CAND;
          end
        end
      end
      S_CAND: begin
        if (c_r <= W'(LAST_TRIVIAL)) begin
          found = 1'b1;
        end else if (!c_r[0]) begin
          reject = 1'b1;
        end else begin
          dsr_nxt       = W'(DIV_THREE);
          div_start_nxt = 1'b1;
          state_nxt     = S_DIV3;
        end
      end
      S_DIV3: begin
        if (div_done) begin
          if (div_rem == '0) begin
            reject = 1'b1;
          end else begin
            d_nxt         = W'(FIRST_DIVISOR);
            dsr_nxt       = W'(FIRST_DIVISOR);
            div_start_nxt = 1'b1;
            state_nxt     = S_DIVA;
          end
        end
      end
      S_DIVA: begin
        if (div_done) begin
          if (d_r > div_quo) begin
            found = 1'b1;
          end else if (div_rem == '0) begin
            reject = 1'b1;
          end else begin
            dsr_nxt       = d_r + W'(PAIR_GAP);
            div_start_nxt = 1'b1;
            state_nxt     = S_DIVB;
          end
        end
      end
      S_DIVB: begin
        if (div_done) begin
          if (div_rem == '0) begin
            reject = 1'b1;
          end else begin
            d_nxt         = d_r + W'(DIVISOR_STEP);
            dsr_nxt       = d_r + W'(DIVISOR_STEP);
            div_start_nxt = 1'b1;
            state_nxt     = S_DIVA;
          end
        end
      end
      S_OUT: begin
        if (out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (found) begin
      prime_nxt = PRIME_W'(c_r);
      ovf_nxt   = 1'b0;
      state_nxt = S_OUT;
    end else if (reject) begin
      if (c_r == MASK) begin
        prime_nxt = '0;
        ovf_nxt   = 1'b1;
        state_nxt = S_OUT;
      end else begin
        c_nxt     = c_r + W'(1);
        state_nxt = S_CAND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    dsr_r   <= dsr_nxt;
    prime_r <= prime_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = (state_r == S_OUT);
  assign out_chan.prime_found = prime_r;
  assign out_chan.overflow    = ovf_r;

  // A taken input beat closes the input side until its result has gone out.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input accepted again before the result beat");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.overflow |-> out_chan.prime_found == '0)
    else $error("overflow result carries a nonzero prime");

  a_divisor_ok: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> dsr_r >= W'(DIV_THREE))
    else $error("divider started with a divisor below three");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV3 || state_r == S_DIVA || state_r == S_DIVB))
    else $error("divider finished outside a wait state");

endmodule
